// File: rtl/core/value_noise_grass_classifier_unit_defines.svh
// Assertion macros used by the checker file of the grass classifier.
`ifndef VALUE_NOISE_GRASS_CLASSIFIER_UNIT_DEFINES_SVH
`define VALUE_NOISE_GRASS_CLASSIFIER_UNIT_DEFINES_SVH

`define VNGC_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define VNGC_ASSERT(label, prop) \
  `VNGC_ASSERT_MSG(label, prop, "grass classifier check failed")

`endif

// File: rtl/core/vngc_pkg.sv
// Types, constants and helper functions of the grass classifier.
`default_nettype none
package vngc_pkg;

  localparam int NUM_OCT = 2;
  localparam int NUM_FIELD = 3;
  localparam int NUM_CORNER = 4;

  localparam logic [31:0] MUL_X = 32'd374761393;
  localparam logic [31:0] MUL_Z = 32'd668265263;
  localparam logic [31:0] MUL_MIX = 32'd1274126177;

  localparam logic [15:0] SCALE_A = 16'd21627;
  localparam logic [15:0] SCALE_B = 16'd32768;
  localparam logic [15:0] WEIGHT_A = 16'd52429;
  localparam logic [15:0] WEIGHT_B = 16'd13107;

  localparam logic REG_MEDIUM_BIAS = 1'b0;

  typedef logic [15:0] q16_t;

  typedef enum logic [1:0] {
    GT_DARK   = 2'd0,
    GT_MEDIUM = 2'd1,
    GT_LIGHT  = 2'd2
  } grass_t;

  function automatic logic [15:0] oct_scale(input int o);
    return (o == 0) ? SCALE_A : SCALE_B;
  endfunction

  // Hash contribution of the field offset and the corner step.
  function automatic logic [31:0] hash_bias(input int f, input int dx, input int dz);
    logic [63:0] ox;
    logic [63:0] oz;
    logic [63:0] acc;
    case (f)
      0: begin
        ox = 64'd0;
        oz = 64'd0;
      end
      1: begin
        ox = 64'd37;
        oz = 64'd71;
      end
      default: begin
        ox = 64'd113;
        oz = 64'd191;
      end
    endcase
    acc = (ox + 64'(dx)) * 64'(MUL_X) + (oz + 64'(dz)) * 64'(MUL_Z);
    return acc[31:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/vngc_smooth.sv
// Two-stage smoothstep of a Q0.16 fraction.
`default_nettype none
module vngc_smooth (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire vngc_pkg::q16_t t,
  output vngc_pkg::q16_t      s
);
  import vngc_pkg::*;

  q16_t        t_d;
  q16_t        t2;
  logic [31:0] sq;
  logic [17:0] c;
  logic [33:0] sp;

  assign sq = 32'(t) * 32'(t);
  assign c  = 18'd196608 - {1'b0, t_d, 1'b0};
  assign sp = 34'(t2) * 34'(c);

  always_ff @(posedge clk) begin
    if (en) begin
      t_d <= t;
      t2  <= sq[31:16];
      s   <= sp[31:16];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/vngc_hash.sv
// Registered mixing stage of the lattice corner hash.
`default_nettype none
module vngc_hash (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] h0,
  output vngc_pkg::q16_t   corner
);
  import vngc_pkg::*;

  logic [31:0] pre;
  logic [31:0] mixed;

  assign pre = h0 ^ (h0 >> 13);

  always_ff @(posedge clk) begin
    if (en) begin
      mixed <= pre * MUL_MIX;
    end
  end

  // The final xor with the upper half leaves the upper half unchanged.
  assign corner = mixed[31:16];

endmodule
`default_nettype wire

// File: rtl/core/vngc_blend.sv
// Linear interpolation of two Q0.16 values by a Q0.16 weight.
`default_nettype none
module vngc_blend (
  input  wire vngc_pkg::q16_t a,
  input  wire vngc_pkg::q16_t b,
  input  wire vngc_pkg::q16_t s,
  output vngc_pkg::q16_t      y
);
  import vngc_pkg::*;

  logic [16:0] ws;
  logic [33:0] acc;

  assign ws  = 17'd65536 - {1'b0, s};
  assign acc = 34'(a) * 34'(ws) + 34'(b) * 34'(s);
  assign y   = acc[31:16];

endmodule
`default_nettype wire

// File: rtl/core/value_noise_grass_classifier_unit.sv
// Top level of the value noise grass classifier.
// The block takes one world position (pos_x, pos_z, signed Q15.8) per item on
// the input channel and returns one item on the output channel holding the
// grass type and the dark, medium and light field levels.
// Both channels use valid and ready; an item moves when both are high.
// The pipeline has seven register stages: the first captures the item at the
// edge that accepts it. One item can be accepted every cycle unless a finished
// result waits and is not taken.
// The stages hold the chain of scale multiply, hash multiplies,
// smoothstep, two interpolations and the octave weighting.
// When the receiver stalls, the whole pipeline holds and in_ready drops only
// while a finished result waits and is not taken; nothing is lost or repeated.
// Reset clears all valid bits and sets medium_bias to zero.
// The medium_bias register sits at byte address 0 of the APB port and should
// be written only while the pipeline is empty.
`default_nettype none
module value_noise_grass_classifier_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] pos_x,
  input  wire logic signed [23:0] pos_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              grass_type,
  output logic [16:0]             dark_level,
  output logic [16:0]             medium_level,
  output logic [16:0]             light_level
);
  import vngc_pkg::*;

  logic        en;
  logic [15:0] medium_bias;
  logic        v1, v2, v3, v4, v5, v6;

  logic signed [16:0] cell_x [NUM_OCT];
  logic signed [16:0] cell_z [NUM_OCT];
  q16_t               frac_x [NUM_OCT];
  q16_t               frac_z [NUM_OCT];
  logic [31:0]        base_x [NUM_OCT];
  logic [31:0]        base_z [NUM_OCT];
  q16_t               sx [NUM_OCT];
  q16_t               sz [NUM_OCT];
  q16_t               sz4 [NUM_OCT];
  q16_t               corner [NUM_OCT][NUM_FIELD][NUM_CORNER];
  q16_t               top_c [NUM_OCT][NUM_FIELD];
  q16_t               bot_c [NUM_OCT][NUM_FIELD];
  q16_t               top_r [NUM_OCT][NUM_FIELD];
  q16_t               bot_r [NUM_OCT][NUM_FIELD];
  q16_t               noise_c [NUM_OCT][NUM_FIELD];
  q16_t               noise_r [NUM_OCT][NUM_FIELD];
  logic [16:0]        fld [NUM_FIELD];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_MEDIUM_BIAS) ? {16'd0, medium_bias} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      medium_bias <= 16'd0;
    end else if (psel && penable && pwrite && paddr[2] == REG_MEDIUM_BIAS) begin
      medium_bias <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  for (genvar o = 0; o < NUM_OCT; o++) begin : g_oct
    logic signed [40:0] px;
    logic signed [40:0] pz;
    logic [31:0]        cx32;
    logic [31:0]        cz32;

    assign px   = 41'(pos_x) * $signed({25'd0, oct_scale(o)});
    assign pz   = 41'(pos_z) * $signed({25'd0, oct_scale(o)});
    assign cx32 = 32'(cell_x[o]);
    assign cz32 = 32'(cell_z[o]);

    always_ff @(posedge clk) begin
      if (en) begin
        cell_x[o] <= px[40:24];
        cell_z[o] <= pz[40:24];
        frac_x[o] <= px[23:8];
        frac_z[o] <= pz[23:8];
        base_x[o] <= cx32 * MUL_X;
        base_z[o] <= cz32 * MUL_Z;
        sz4[o]    <= sz[o];
      end
    end

    vngc_smooth u_smooth_x (.clk(clk), .en(en), .t(frac_x[o]), .s(sx[o]));
    vngc_smooth u_smooth_z (.clk(clk), .en(en), .t(frac_z[o]), .s(sz[o]));

    for (genvar f = 0; f < NUM_FIELD; f++) begin : g_field
      for (genvar c = 0; c < NUM_CORNER; c++) begin : g_corner
        logic [31:0] h0;
        assign h0 = base_x[o] + base_z[o] + hash_bias(f, c % 2, c / 2);
        vngc_hash u_hash (.clk(clk), .en(en), .h0(h0), .corner(corner[o][f][c]));
      end

      vngc_blend u_top (
        .a(corner[o][f][0]), .b(corner[o][f][1]), .s(sx[o]), .y(top_c[o][f])
      );
      vngc_blend u_bot (
        .a(corner[o][f][2]), .b(corner[o][f][3]), .s(sx[o]), .y(bot_c[o][f])
      );
      vngc_blend u_vert (
        .a(top_r[o][f]), .b(bot_r[o][f]), .s(sz4[o]), .y(noise_c[o][f])
      );

      always_ff @(posedge clk) begin
        if (en) begin
          top_r[o][f]   <= top_c[o][f];
          bot_r[o][f]   <= bot_c[o][f];
          noise_r[o][f] <= noise_c[o][f];
        end
      end
    end
  end

  for (genvar f = 0; f < NUM_FIELD; f++) begin : g_sum
    logic [32:0] wsum;
    logic [16:0] bias_add;
    assign wsum = 33'(noise_r[0][f]) * 33'(WEIGHT_A) + 33'(noise_r[1][f]) * 33'(WEIGHT_B);
    assign bias_add = (f == 1) ? {1'b0, medium_bias} : 17'd0;
    always_ff @(posedge clk) begin
      if (en) begin
        fld[f] <= {1'b0, wsum[31:16]} + bias_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dark_level   <= fld[0];
      medium_level <= fld[1];
      light_level  <= fld[2];
      if (fld[0] > fld[1] && fld[0] > fld[2]) begin
        grass_type <= GT_DARK;
      end else if (fld[1] > fld[2]) begin
        grass_type <= GT_MEDIUM;
      end else begin
        grass_type <= GT_LIGHT;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/vngc_checker.sv
// Port-level checker of the grass classifier and its bind statement.
`default_nettype none
`include "value_noise_grass_classifier_unit_defines.svh"
module vngc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  grass_type,
  input wire logic [16:0] dark_level,
  input wire logic [16:0] medium_level,
  input wire logic [16:0] light_level
);
  import vngc_pkg::*;

  logic dark_top;
  logic medium_over;

  assign dark_top    = dark_level > medium_level && dark_level > light_level;
  assign medium_over = medium_level > light_level;

  `VNGC_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(grass_type))
  `VNGC_ASSERT(a_ready, !out_valid |-> in_ready)
  `VNGC_ASSERT(a_dark, out_valid && grass_type == GT_DARK |-> dark_top)
  `VNGC_ASSERT(a_medium, out_valid && grass_type == GT_MEDIUM |-> medium_over)

endmodule

bind value_noise_grass_classifier_unit vngc_checker u_vngc_checker (.*);
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the value noise grass classifier unit.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vngc_pkg::*;

  class grass_scoreboard;
    logic [1:0]  q_type[$];
    logic [16:0] q_dark[$];
    logic [16:0] q_med[$];
    logic [16:0] q_light[$];
    int errors = 0;
    int inputs = 0;
    int results = 0;
    logic [15:0] bias = 16'd0;

    function automatic logic [15:0] corner(logic [31:0] cx, logic [31:0] cz);
      logic [31:0] h;
      h = cx * MUL_X + cz * MUL_Z;
      h = (h ^ (h >> 13)) * MUL_MIX;
      h = h ^ (h >> 16);
      return h[31:16];
    endfunction

    function automatic logic [15:0] smooth(logic [15:0] t);
      logic [63:0] t2;
      logic [63:0] c;
      logic [63:0] s;
      t2 = (64'(t) * 64'(t)) >> 16;
      c = 64'd196608 - 64'd2 * 64'(t);
      s = (t2 * c) >> 16;
      return s[15:0];
    endfunction

    function automatic logic [15:0] lerp(logic [15:0] a, logic [15:0] b, logic [15:0] s);
      logic [63:0] v;
      v = 64'(a) * (64'd65536 - 64'(s)) + 64'(b) * 64'(s);
      return v[31:16];
    endfunction

    function automatic logic [15:0] sample(logic signed [23:0] px, logic signed [23:0] pz,
                                           logic [15:0] sc, longint ox, longint oz);
      longint ux;
      longint uz;
      logic [31:0] x0;
      logic [31:0] z0;
      logic [15:0] sx;
      logic [15:0] sz;
      logic [15:0] top;
      logic [15:0] bot;
      ux = longint'(px) * longint'({1'b0, sc}) + ox * 64'sd16777216;
      uz = longint'(pz) * longint'({1'b0, sc}) + oz * 64'sd16777216;
      x0 = 32'(ux >>> 24);
      z0 = 32'(uz >>> 24);
      sx = smooth(ux[23:8]);
      sz = smooth(uz[23:8]);
      top = lerp(corner(x0, z0), corner(x0 + 1, z0), sx);
      bot = lerp(corner(x0, z0 + 1), corner(x0 + 1, z0 + 1), sx);
      return lerp(top, bot, sz);
    endfunction

    function automatic logic [16:0] field(logic signed [23:0] px, logic signed [23:0] pz,
                                          longint ox, longint oz);
      logic [63:0] v;
      v = 64'(sample(px, pz, SCALE_A, ox, oz)) * 64'(WEIGHT_A)
        + 64'(sample(px, pz, SCALE_B, ox, oz)) * 64'(WEIGHT_B);
      return v[32:16];
    endfunction

    function void note_position(logic signed [23:0] px, logic signed [23:0] pz);
      logic [16:0] d;
      logic [16:0] m;
      logic [16:0] l;
      logic [1:0] g;
      d = field(px, pz, 0, 0);
      m = field(px, pz, 37, 71) + 17'(bias);
      l = field(px, pz, 113, 191);
      if (d > m && d > l) g = GT_DARK;
      else if (m > l) g = GT_MEDIUM;
      else g = GT_LIGHT;
      q_type = {q_type, g};
      q_dark = {q_dark, d};
      q_med = {q_med, m};
      q_light = {q_light, l};
      inputs++;
    endfunction

    function void check_levels(logic [1:0] g, logic [16:0] d, logic [16:0] m, logic [16:0] l);
      logic [1:0] eg;
      logic [16:0] ed;
      logic [16:0] em;
      logic [16:0] el;
      results++;
      if (q_type.size() == 0) begin
        $error("result with no pending position");
        errors++;
        return;
      end
      eg = q_type.pop_front();
      ed = q_dark.pop_front();
      em = q_med.pop_front();
      el = q_light.pop_front();
      if (g !== eg) begin
        $error("grass_type expected %0d actual %0d", eg, g);
        errors++;
      end
      if (d !== ed) begin
        $error("dark_level expected %0d actual %0d", ed, d);
        errors++;
      end
      if (m !== em) begin
        $error("medium_level expected %0d actual %0d", em, m);
        errors++;
      end
      if (l !== el) begin
        $error("light_level expected %0d actual %0d", el, l);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic signed [23:0] pos_x = 24'sd0, pos_z = 24'sd0;
  logic out_valid, out_ready = 1'b0;
  logic [1:0] grass_type;
  logic [16:0] dark_level, medium_level, light_level;

  grass_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 1'b0;

  always #5 clk = ~clk;

  value_noise_grass_classifier_unit uut (.*);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_levels(grass_type, dark_level, medium_level, light_level);
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_bias(logic [15:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.bias = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (prdata !== {16'd0, v}) begin
      $error("prdata expected %0d actual %0d", v, prdata);
      sb.errors++;
    end
  endtask

  task automatic send_position(logic signed [23:0] x, logic signed [23:0] z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= x;
    pos_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_position(x, z);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.q_type.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_burst(int n);
    logic signed [23:0] x;
    logic signed [23:0] z;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: begin
          x = 24'($urandom);
          z = 24'($urandom);
        end
        1: begin
          x = 24'($urandom_range(8191)) - 24'sd4096;
          z = 24'($urandom_range(8191)) - 24'sd4096;
        end
        2: begin
          x = ($urandom_range(1)) ? 24'sh7FFFFF - 24'($urandom_range(255))
                                  : 24'sh800000 + 24'($urandom_range(255));
          z = 24'($urandom);
        end
        default: begin
          x = 24'($urandom_range(255)) << 8;
          z = 24'($urandom_range(255)) << 8;
        end
      endcase
      send_position(x, z);
    end
  endtask

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle = 0;
    recv_idle = 0;
    send_position(24'sd0, 24'sd0);
    send_position(24'sh7FFFFF, 24'sh7FFFFF);
    send_position(24'sh800000, 24'sh800000);
    send_position(24'sh7FFFFF, 24'sh800000);
    send_position(24'sh800000, 24'sh7FFFFF);
    send_position(-24'sd1, -24'sd1);
    send_position(24'sd1, 24'sd256);
    send_position(24'sd256, -24'sd256);
    send_position(24'sh555555, 24'shAAAAAA);
    send_position(24'shAAAAAA, 24'sh555555);
    drain();
    write_bias(16'hFFFF);
    send_position(24'sd0, 24'sd0);
    send_position(24'sh7FFFFF, 24'sh800000);
    send_position(24'sd1000, -24'sd1000);
    drain();
    write_bias(16'd5243);
    send_position(24'sd0, 24'sd0);
    send_position(24'sh123456, 24'shFEDCBA);
    drain();

    send_idle = 34;
    recv_idle = 63;
    random_burst(500);
    drain();
    write_bias(16'd0);
    send_idle = 63;
    recv_idle = 34;
    random_burst(500);
    drain();
    write_bias(16'($urandom));
    send_idle = 0;
    recv_idle = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      random_burst(100);
    join
    random_burst(430);
    drain();

    $display("Checked %0d positions against %0d results over four bias settings,",
             sb.inputs, sb.results);
    $display("with both sides stalling and one long receiver hold-off.");
    if (sb.errors == 0 && sb.q_type.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
